### rtl/csvfs_pkg.sv
// Package for the CSV field splitter: result kinds, the command record that
// passes from the front part to the back part, sequencer phases and the default text.
// Depends on nothing; the front, back and top-level files use it by scoped names.
`default_nettype none

package csvfs_pkg;

  // Bytes of special meaning in the line.
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // Result kinds as they appear on the kind port.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_LINE  = 2'd2;

  // Default text emitted for an empty field after a comma.
  localparam int DEFAULT_LEN = 13;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Work that one accepted item leaves for the back part, in emission order:
  // default text with its close, a field close, one field byte, line complete.
  typedef struct packed {
    logic       do_default;
    logic [2:0] default_idx;
    logic       do_close;
    logic [2:0] close_idx;
    logic       do_byte;
    logic [2:0] byte_idx;
    logic [7:0] byte_char;
    logic       do_line;
    logic       line_ovf;
  } cmd_t;

  // Phases of the back sequencer; PH_NONE means no phase is left.
  typedef enum logic [2:0] {
    PH_NONE,
    PH_DEF_BYTES,
    PH_DEF_CLOSE,
    PH_CLOSE,
    PH_BYTE,
    PH_LINE
  } phase_t;

  // Returns the phase that follows ph for the given command.
  function automatic phase_t next_phase(input cmd_t cmd, input phase_t ph);
    phase_t nxt;
    nxt = PH_NONE;
    case (ph)
      PH_NONE: begin
        if (cmd.do_default)    nxt = PH_DEF_BYTES;
        else if (cmd.do_close) nxt = PH_CLOSE;
        else if (cmd.do_byte)  nxt = PH_BYTE;
        else if (cmd.do_line)  nxt = PH_LINE;
      end
      PH_DEF_BYTES: nxt = PH_DEF_CLOSE;
      PH_DEF_CLOSE: begin
        if (cmd.do_close)      nxt = PH_CLOSE;
        else if (cmd.do_byte)  nxt = PH_BYTE;
        else if (cmd.do_line)  nxt = PH_LINE;
      end
      PH_CLOSE: begin
        if (cmd.do_byte)       nxt = PH_BYTE;
        else if (cmd.do_line)  nxt = PH_LINE;
      end
      PH_BYTE: begin
        if (cmd.do_line)       nxt = PH_LINE;
      end
      PH_LINE: nxt = PH_NONE;
      default: nxt = PH_NONE;
    endcase
    return nxt;
  endfunction

  // Characters of the default text "nao informado".
  function automatic logic [7:0] default_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h6E; // n
      4'd1:    ch = 8'h61; // a
      4'd2:    ch = 8'h6F; // o
      4'd3:    ch = 8'h20; // space
      4'd4:    ch = 8'h69; // i
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h66; // f
      4'd7:    ch = 8'h6F; // o
      4'd8:    ch = 8'h72; // r
      4'd9:    ch = 8'h6D; // m
      4'd10:   ch = 8'h61; // a
      4'd11:   ch = 8'h64; // d
      4'd12:   ch = 8'h6F; // o
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

### rtl/csvfs_front.sv
// Front part of the CSV field splitter: tracks the line state and turns each
// accepted byte or terminator into at most one command record. Depends on csvfs_pkg.
`default_nettype none

module csvfs_front #(
  parameter int MAX_FIELDS    = 8,
  parameter int MAX_FIELD_LEN = 100
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic [7:0]     char_in,
  input  wire logic           line_end,
  output csvfs_pkg::cmd_t     cmd,
  output logic                push
);

  localparam logic [3:0] FIELD_LIMIT = 4'(MAX_FIELDS);
  localparam logic [6:0] LEN_LIMIT   = 7'(MAX_FIELD_LEN);

  // Line state registers.
  logic       field_open;
  logic [3:0] field_number;
  logic [6:0] byte_count;
  logic       comma_pending;
  logic       line_overflow;

  logic       field_open_next;
  logic [3:0] field_number_next;
  logic [6:0] byte_count_next;
  logic       comma_pending_next;
  logic       line_overflow_next;

  // Classification and the command for the current item.
  logic       is_comma;
  logic       is_newline;
  logic       def_req;
  logic       def_ok;
  logic [3:0] fn_after_def;
  logic       closing;
  logic       close_ok;
  logic [3:0] fn_after_close;
  logic       storing;
  logic [6:0] count_base;
  logic       byte_ok;
  logic       ovf;

  always_comb begin
    is_comma   = (char_in == csvfs_pkg::CHAR_COMMA);
    is_newline = (char_in == csvfs_pkg::CHAR_NEWLINE);

    // A pending comma sees its lookahead: comma, newline or line end gives default text.
    def_req      = comma_pending && (line_end || is_comma || is_newline);
    def_ok       = def_req && (field_number < FIELD_LIMIT);
    fn_after_def = def_ok ? 4'(field_number + 4'd1) : field_number;

    // A comma or the line end closes an open field.
    closing        = field_open && (line_end || is_comma);
    close_ok       = closing && (fn_after_def < FIELD_LIMIT);
    fn_after_close = close_ok ? 4'(fn_after_def + 4'd1) : fn_after_def;

    // Any other byte is stored in the open field, opening one if needed.
    storing    = !line_end && !is_comma && !is_newline;
    count_base = field_open ? byte_count : 7'd0;
    byte_ok    = storing && (fn_after_def < FIELD_LIMIT) && (count_base < LEN_LIMIT);

    ovf = line_overflow || (def_req && !def_ok)
          || (storing && (fn_after_def >= FIELD_LIMIT) && !field_open)
          || (storing && (fn_after_def < FIELD_LIMIT) && (count_base >= LEN_LIMIT));
  end

  // Command record handed to the queue.
  always_comb begin
    cmd.do_default  = def_ok;
    cmd.default_idx = field_number[2:0];
    cmd.do_close    = close_ok;
    cmd.close_idx   = fn_after_def[2:0];
    cmd.do_byte     = byte_ok;
    cmd.byte_idx    = fn_after_def[2:0];
    cmd.byte_char   = char_in;
    cmd.do_line     = line_end;
    cmd.line_ovf    = ovf;
    push = accept && (def_ok || close_ok || byte_ok || line_end);
  end

  // Next line state; the terminator clears everything for the next line.
  always_comb begin
    field_open_next    = field_open;
    field_number_next  = field_number;
    byte_count_next    = byte_count;
    comma_pending_next = comma_pending;
    line_overflow_next = line_overflow;
    if (accept) begin
      if (line_end) begin
        field_open_next    = 1'b0;
        field_number_next  = 4'd0;
        byte_count_next    = 7'd0;
        comma_pending_next = 1'b0;
        line_overflow_next = 1'b0;
      end else begin
        comma_pending_next = is_comma;
        field_number_next  = fn_after_close;
        line_overflow_next = ovf;
        if (closing) begin
          field_open_next = 1'b0;
          byte_count_next = 7'd0;
        end else if (storing) begin
          field_open_next = 1'b1;
          byte_count_next = byte_ok ? 7'(count_base + 7'd1) : count_base;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_open    <= 1'b0;
      field_number  <= 4'd0;
      byte_count    <= 7'd0;
      comma_pending <= 1'b0;
      line_overflow <= 1'b0;
    end else begin
      field_open    <= field_open_next;
      field_number  <= field_number_next;
      byte_count    <= byte_count_next;
      comma_pending <= comma_pending_next;
      line_overflow <= line_overflow_next;
    end
  end

endmodule

`default_nettype wire

### rtl/csvfs_fifo.sv
// Short command queue between the front and back parts of the CSV field
// splitter. Generic width and depth; depends on nothing.
`default_nettype none

module csvfs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head,
  output logic                  empty,
  output logic                  full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  always_comb begin
    empty   = (count == '0);
    full    = (count == CNT_DEPTH);
    do_push = push && !full;
    do_pop  = pop && !empty;
    head    = entries[rd_ptr];
  end

  // Entry storage holds payload only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/csvfs_back.sv
// Back part of the CSV field splitter: expands each queued command into its
// results to an output register, one per cycle unless stalled. Uses csvfs_pkg.
`default_nettype none

module csvfs_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire csvfs_pkg::cmd_t head,
  input  wire logic            empty,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [1:0]           kind,
  output logic [2:0]           field_index,
  output logic [7:0]           out_char,
  output logic                 overflow,
  output logic                 last
);

  localparam logic [3:0] DEF_LAST = 4'(csvfs_pkg::DEFAULT_LEN - 1);

  // Sequencer state.
  csvfs_pkg::cmd_t   cmd;
  csvfs_pkg::cmd_t   cmd_next;
  csvfs_pkg::phase_t phase;
  csvfs_pkg::phase_t phase_next;
  logic [3:0]        cnt;
  logic [3:0]        cnt_next;
  logic              busy;
  logic              busy_next;

  // Result of the current step.
  csvfs_pkg::phase_t later;
  logic              done;
  logic              step;
  logic [1:0]        res_kind;
  logic [2:0]        res_index;
  logic [7:0]        res_char;
  logic              res_ovf;

  // Outputs of the current phase.
  always_comb begin
    later     = csvfs_pkg::next_phase(cmd, phase);
    done      = (phase != csvfs_pkg::PH_DEF_BYTES || cnt == DEF_LAST)
                && (later == csvfs_pkg::PH_NONE);
    step      = busy && (!out_valid || out_ready);
    res_kind  = csvfs_pkg::KIND_BYTE;
    res_index = 3'd0;
    res_char  = 8'd0;
    res_ovf   = 1'b0;
    case (phase)
      csvfs_pkg::PH_DEF_BYTES: begin
        res_index = cmd.default_idx;
        res_char  = csvfs_pkg::default_char(cnt);
      end
      csvfs_pkg::PH_DEF_CLOSE: begin
        res_kind  = csvfs_pkg::KIND_CLOSE;
        res_index = cmd.default_idx;
      end
      csvfs_pkg::PH_CLOSE: begin
        res_kind  = csvfs_pkg::KIND_CLOSE;
        res_index = cmd.close_idx;
      end
      csvfs_pkg::PH_BYTE: begin
        res_index = cmd.byte_idx;
        res_char  = cmd.byte_char;
      end
      csvfs_pkg::PH_LINE: begin
        res_kind = csvfs_pkg::KIND_LINE;
        res_ovf  = cmd.line_ovf;
      end
      default: begin
        res_kind = csvfs_pkg::KIND_BYTE;
      end
    endcase
  end

  // Next state: advance through the phases, and load the next command
  // in the same cycle as the last result of the current one.
  always_comb begin
    cmd_next   = cmd;
    phase_next = phase;
    cnt_next   = cnt;
    busy_next  = busy;
    pop        = (!busy || (step && done)) && !empty;
    if (pop) begin
      cmd_next   = head;
      phase_next = csvfs_pkg::next_phase(head, csvfs_pkg::PH_NONE);
      cnt_next   = 4'd0;
      busy_next  = 1'b1;
    end else if (step && done) begin
      busy_next  = 1'b0;
    end else if (step) begin
      if (phase == csvfs_pkg::PH_DEF_BYTES && cnt != DEF_LAST) begin
        cnt_next = 4'(cnt + 4'd1);
      end else begin
        phase_next = later;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd   <= cmd_next;
    cnt   <= cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= csvfs_pkg::PH_NONE;
      busy  <= 1'b0;
    end else begin
      phase <= phase_next;
      busy  <= busy_next;
    end
  end

  // Output register: filled on each step, emptied by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      kind        <= res_kind;
      field_index <= res_index;
      out_char    <= res_char;
      overflow    <= res_ovf;
      last        <= done;
    end
  end

endmodule

`default_nettype wire

### rtl/csv_field_splitter.sv
// Top level of the CSV field splitter: front part, command queue and back part.
// Depends on csvfs_pkg, csvfs_front, csvfs_fifo and csvfs_back.
//
// The block takes one byte of a comma-separated line per cycle, with a
// terminator item (line_end) closing the line, and returns numbered field
// bytes, field-closed marks and one line-complete result carrying the overflow
// flag; last marks the final result caused by an input. Input is accepted every
// cycle while the four-entry command queue has room, even while a result waits
// at the output. An empty field expands into 14 results for its default text
// and close, so during such an expansion the queue fills and input stalls. The
// first result of an input passes the command queue, the back command register
// and the output register. No clearing pass is needed after reset.
`default_nettype none

module csv_field_splitter #(
  parameter int MAX_FIELDS    = 8,
  parameter int MAX_FIELD_LEN = 100
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_in,
  input  wire logic       line_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [2:0]      field_index,
  output logic [7:0]      out_char,
  output logic            overflow,
  output logic            last
);

  csvfs_pkg::cmd_t front_cmd;
  csvfs_pkg::cmd_t queue_head;
  logic            push;
  logic            pop;
  logic            empty;
  logic            full;
  logic            accept;

  // An input transfer needs a free queue entry.
  always_comb begin
    in_ready = !full;
    accept   = in_valid && in_ready;
  end

  csvfs_front #(
    .MAX_FIELDS    (MAX_FIELDS),
    .MAX_FIELD_LEN (MAX_FIELD_LEN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .char_in  (char_in),
    .line_end (line_end),
    .cmd      (front_cmd),
    .push     (push)
  );

  csvfs_fifo #(
    .WIDTH ($bits(csvfs_pkg::cmd_t)),
    .DEPTH (csvfs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cmd),
    .pop       (pop),
    .head      (queue_head),
    .empty     (empty),
    .full      (full)
  );

  csvfs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (queue_head),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .field_index (field_index),
    .out_char    (out_char),
    .overflow    (overflow),
    .last        (last)
  );

  // Only field bytes carry a character.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != csvfs_pkg::KIND_BYTE) |-> (out_char == 8'd0))
    else $error("non-byte result carries a character");

  // The line-complete result is always the last one of its input and has index zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == csvfs_pkg::KIND_LINE) |-> last && (field_index == 3'd0))
    else $error("line-complete result malformed");

  // Overflow is reported only on the line-complete result.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != csvfs_pkg::KIND_LINE) |-> !overflow)
    else $error("overflow flag on a field result");

  // A queue pop is never taken from an empty queue.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty command queue");

endmodule

`default_nettype wire
